### rtl/median_ir_distance_converter_core_assert.svh
// Assertion macros for the median IR distance converter core.
`ifndef MEDIAN_IR_DISTANCE_CONVERTER_CORE_ASSERT_SVH
`define MEDIAN_IR_DISTANCE_CONVERTER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MIRDC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mirdc: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MIRDC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mirdc: next-cycle check failed");

`endif

### rtl/mirdc_pkg.sv
// Shared types, codes and calibration tables for the median IR distance converter.
package mirdc_pkg;

    localparam logic OP_PUSH    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam logic CHAN_A = 1'b0;
    localparam logic CHAN_B = 1'b1;

    localparam int SLOPE_W = 17;
    localparam int ICPT_W  = 21;
    localparam int PROD_W  = 26;
    localparam int ACC_W   = 27;
    localparam int FRAC_W  = 12;
    localparam int SEG_W   = 3;
    localparam int LAST_SEG = 6;

    typedef logic signed [SLOPE_W-1:0] slope_t;
    typedef logic [ICPT_W-1:0]         icpt_t;
    typedef logic [SEG_W-1:0]          seg_t;

    typedef struct packed {
        logic push;
        logic scan_clear;
        logic scan;
        logic mul;
        logic sum;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
    } status_t;

    function automatic slope_t slope_of(input logic chan, input seg_t seg);
        slope_t s;
        s = '0;
        if (chan == CHAN_A) begin
            case (seg)
                3'd0:    s = -17'sd476;
                3'd1:    s = -17'sd1107;
                3'd2:    s = -17'sd2926;
                3'd3:    s = -17'sd3724;
                3'd4:    s = -17'sd4551;
                3'd5:    s = -17'sd40960;
                3'd6:    s = -17'sd13653;
                default: s = '0;
            endcase
        end else begin
            case (seg)
                3'd0:    s = -17'sd506;
                3'd1:    s = -17'sd1170;
                3'd2:    s = -17'sd2409;
                3'd3:    s = -17'sd4096;
                3'd4:    s = -17'sd4551;
                3'd5:    s = -17'sd6827;
                3'd6:    s = -17'sd20480;
                default: s = '0;
            endcase
        end
        return s;
    endfunction

    function automatic icpt_t icpt_of(input logic chan, input seg_t seg);
        icpt_t c;
        c = '0;
        if (chan == CHAN_A) begin
            case (seg)
                3'd0:    c = 21'd126690;
                3'd1:    c = 21'd185981;
                3'd2:    c = 21'd289646;
                3'd3:    c = 21'd323956;
                3'd4:    c = 21'd350436;
                3'd5:    c = 21'd1187840;
                3'd6:    c = 21'd587093;
                default: c = '0;
            endcase
        end else begin
            case (seg)
                3'd0:    c = 21'd128442;
                3'd1:    c = 21'd189586;
                3'd2:    c = 21'd260216;
                3'd3:    c = 21'd327680;
                3'd4:    c = 21'd341333;
                3'd5:    c = 21'd389120;
                3'd6:    c = 21'd593920;
                default: c = '0;
            endcase
        end
        return c;
    endfunction

    function automatic logic [7:0] thr_of(input logic chan, input seg_t k);
        logic [7:0] t;
        t = '0;
        if (chan == CHAN_A) begin
            case (k)
                3'd0:    t = 8'd180;
                3'd1:    t = 8'd94;
                3'd2:    t = 8'd57;
                3'd3:    t = 8'd43;
                3'd4:    t = 8'd32;
                3'd5:    t = 8'd23;
                3'd6:    t = 8'd21;
                default: t = 8'd19;
            endcase
        end else begin
            case (k)
                3'd0:    t = 8'd173;
                3'd1:    t = 8'd92;
                3'd2:    t = 8'd57;
                3'd3:    t = 8'd40;
                3'd4:    t = 8'd30;
                3'd5:    t = 8'd21;
                3'd6:    t = 8'd15;
                default: t = 8'd13;
            endcase
        end
        return t;
    endfunction

endpackage

### rtl/mirdc_ctrl.sv
// Controller state machine: sequences push, median scan and calibration.
module mirdc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               opcode,
    input  mirdc_pkg::status_t status,
    output mirdc_pkg::cmd_t    cmd,
    output logic               busy,
    output logic               done
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_SUM   = 3'd3;

    logic [2:0] state_reg, state_next;
    logic       done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start) begin
                    if (opcode == mirdc_pkg::OP_PUSH) begin
                        cmd.push = 1'b1;
                    end else begin
                        cmd.scan_clear = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign done_next = (state_reg == ST_SUM);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

### rtl/mirdc_calib.sv
// Piecewise linear calibration of one median: segment pick, multiply, add, saturate.
module mirdc_calib (
    input  logic       clk,
    input  logic       chan,
    input  logic       mul_en,
    input  logic       sum_en,
    input  logic [7:0] median,
    output logic [7:0] distance
);

    mirdc_pkg::seg_t                        seg;
    logic signed [mirdc_pkg::PROD_W-1:0]    prod_reg, prod_next;
    mirdc_pkg::icpt_t                       icpt_reg;
    logic signed [mirdc_pkg::ACC_W-1:0]     acc;
    logic [7:0]                             dist_reg, dist_next;

    // Thresholds descend, so the lowest index that matches wins.
    always_comb
    begin
        seg = mirdc_pkg::seg_t'(mirdc_pkg::LAST_SEG);
        for (int k = mirdc_pkg::LAST_SEG - 1; k >= 0; k--) begin
            if (median >= mirdc_pkg::thr_of(chan, mirdc_pkg::seg_t'(k))) begin
                seg = mirdc_pkg::seg_t'(k);
            end
        end
    end

    assign prod_next = mirdc_pkg::slope_of(chan, seg) * $signed({1'b0, median});

    assign acc = $signed({prod_reg[mirdc_pkg::PROD_W-1], prod_reg})
               + $signed({{(mirdc_pkg::ACC_W - mirdc_pkg::ICPT_W){1'b0}}, icpt_reg});

    // Clamp negative or zero to 0, anything from 256 up to 255.
    always_comb
    begin
        if (acc[mirdc_pkg::ACC_W-1] || (acc == '0)) begin
            dist_next = 8'd0;
        end else if (|acc[mirdc_pkg::ACC_W-2:mirdc_pkg::FRAC_W+8]) begin
            dist_next = 8'd255;
        end else begin
            dist_next = acc[mirdc_pkg::FRAC_W+7:mirdc_pkg::FRAC_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_en) begin
            prod_reg <= prod_next;
            icpt_reg <= mirdc_pkg::icpt_of(chan, seg);
        end
        if (sum_en) begin
            dist_reg <= dist_next;
        end
    end

    assign distance = dist_reg;

endmodule

### rtl/mirdc_datapath.sv
// Datapath: sample windows, rank scan for the median, two calibration units.
module mirdc_datapath #(
    parameter int WINDOW = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mirdc_pkg::cmd_t    cmd,
    input  logic [7:0]         sensor_a_raw,
    input  logic [7:0]         sensor_b_raw,
    output mirdc_pkg::status_t status,
    output logic [7:0]         sensor_a_distance,
    output logic [7:0]         sensor_b_distance
);

    localparam int IDX_W   = $clog2(WINDOW);
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int MED_POS = WINDOW / 2;

    logic [7:0]       win_a_reg [WINDOW];
    logic [7:0]       win_b_reg [WINDOW];
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       med_a_reg, med_b_reg;
    logic [7:0]       cand_a, cand_b;
    logic [CNT_W-1:0] lt_a, le_a, lt_b, le_b;
    logic             hit_a, hit_b;
    logic             idx_last;

    assign slot_next = (slot_reg == IDX_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
    assign idx_last  = (idx_reg == IDX_W'(WINDOW - 1));
    assign idx_next  = idx_last ? '0 : idx_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < WINDOW; i++) begin
                win_a_reg[i] <= '0;
                win_b_reg[i] <= '0;
            end
            slot_reg <= '0;
            idx_reg  <= '0;
        end else begin
            if (cmd.push) begin
                win_a_reg[slot_reg] <= sensor_a_raw;
                win_b_reg[slot_reg] <= sensor_b_raw;
                slot_reg            <= slot_next;
            end
            if (cmd.scan_clear) begin
                idx_reg <= '0;
            end else if (cmd.scan) begin
                idx_reg <= idx_next;
            end
        end
    end

    // Rank the candidate against the whole window of each channel.
    assign cand_a = win_a_reg[idx_reg];
    assign cand_b = win_b_reg[idx_reg];

    always_comb
    begin
        lt_a = '0;
        le_a = '0;
        lt_b = '0;
        le_b = '0;
        for (int j = 0; j < WINDOW; j++) begin
            lt_a = lt_a + CNT_W'(win_a_reg[j] <  cand_a);
            le_a = le_a + CNT_W'(win_a_reg[j] <= cand_a);
            lt_b = lt_b + CNT_W'(win_b_reg[j] <  cand_b);
            le_b = le_b + CNT_W'(win_b_reg[j] <= cand_b);
        end
    end

    // The candidate sits at the median position when its rank span covers it.
    assign hit_a = (lt_a <= CNT_W'(MED_POS)) && (le_a > CNT_W'(MED_POS));
    assign hit_b = (lt_b <= CNT_W'(MED_POS)) && (le_b > CNT_W'(MED_POS));

    always_ff @(posedge clk)
    begin
        if (cmd.scan && hit_a) begin
            med_a_reg <= cand_a;
        end
        if (cmd.scan && hit_b) begin
            med_b_reg <= cand_b;
        end
    end

    assign status.scan_last = idx_last;

    mirdc_calib u_calib_a (
        .clk      (clk),
        .chan     (mirdc_pkg::CHAN_A),
        .mul_en   (cmd.mul),
        .sum_en   (cmd.sum),
        .median   (med_a_reg),
        .distance (sensor_a_distance)
    );

    mirdc_calib u_calib_b (
        .clk      (clk),
        .chan     (mirdc_pkg::CHAN_B),
        .mul_en   (cmd.mul),
        .sum_en   (cmd.sum),
        .median   (med_b_reg),
        .distance (sensor_b_distance)
    );

endmodule

### rtl/median_ir_distance_converter_core.sv
// Push: busy stays low, transactions may come every cycle.
// Request: busy through the scan, multiply and add/clamp states; done is registered from the add/clamp state.
// The rank scan visits one window slot per cycle, then one multiply state and one add/clamp state.
// Next transaction may be accepted in the cycle done is high; results cannot be held off.
// Reset (rst_n low, asynchronous) zeroes both windows, the write slot and the controller.
`include "median_ir_distance_converter_core_assert.svh"

module median_ir_distance_converter_core #(
    parameter int WINDOW = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       opcode,
    input  logic [7:0] sensor_a_raw,
    input  logic [7:0] sensor_b_raw,
    output logic       done,
    output logic [7:0] sensor_a_distance,
    output logic [7:0] sensor_b_distance
);

    mirdc_pkg::cmd_t    cmd;
    mirdc_pkg::status_t status;

    mirdc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    mirdc_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sensor_a_raw      (sensor_a_raw),
        .sensor_b_raw      (sensor_b_raw),
        .status            (status),
        .sensor_a_distance (sensor_a_distance),
        .sensor_b_distance (sensor_b_distance)
    );

    `MIRDC_ASSERT_NEXT(a_done_one_cycle, done, !done)
    `MIRDC_ASSERT_NOW(a_done_while_idle, done, !busy)
    `MIRDC_ASSERT_NEXT(a_request_goes_busy, start && !busy && (opcode == mirdc_pkg::OP_REQUEST), busy && !done)
    `MIRDC_ASSERT_NEXT(a_push_stays_idle, start && !busy && (opcode == mirdc_pkg::OP_PUSH), !busy && !done)

endmodule

### sim/median_distance_checker.sv
// Watches the median IR converter ports, predicts each distance pair and compares it.
module median_distance_checker #(
    parameter int WINDOW = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic       opcode,
    input  logic [7:0] sensor_a_raw,
    input  logic [7:0] sensor_b_raw,
    input  logic       done,
    input  logic [7:0] sensor_a_distance,
    input  logic [7:0] sensor_b_distance,
    output int         errors,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] dist_a;
        logic [7:0] dist_b;
    } dist_pair_t;

    // Calibration per channel: Q.12 slopes and intercepts, descending thresholds
    localparam int SEGS = 7;
    localparam int SLOPE_A [SEGS] = '{-476, -1107, -2926, -3724, -4551, -40960, -13653};
    localparam int ICPT_A  [SEGS] = '{126690, 185981, 289646, 323956, 350436, 1187840, 587093};
    localparam int SLOPE_B [SEGS] = '{-506, -1170, -2409, -4096, -4551, -6827, -20480};
    localparam int ICPT_B  [SEGS] = '{128442, 189586, 260216, 327680, 341333, 389120, 593920};
    localparam int THR_A   [SEGS] = '{180, 94, 57, 43, 32, 23, 21};
    localparam int THR_B   [SEGS] = '{173, 92, 57, 40, 30, 21, 15};

    logic [7:0] win_a [WINDOW];
    logic [7:0] win_b [WINDOW];
    int         slot;
    dist_pair_t dist_due_q [$];

    function automatic logic [7:0] window_median(input logic [7:0] win [WINDOW]);
        logic [7:0] srt [WINDOW];
        logic [7:0] t;
        srt = win;
        for (int i = 0; i < WINDOW - 1; i++)
        begin
            for (int j = 0; j < WINDOW - 1 - i; j++)
            begin
                if (srt[j] > srt[j+1])
                begin
                    t = srt[j];
                    srt[j] = srt[j+1];
                    srt[j+1] = t;
                end
            end
        end
        return srt[WINDOW/2];
    endfunction

    function automatic logic [7:0] calibrated_distance(input logic chan, input logic [7:0] v);
        int seg;
        int acc;
        int whole;
        seg = SEGS - 1;
        // first segment whose threshold the median reaches; below all of them use the last
        for (int k = SEGS - 2; k >= 0; k--)
        begin
            if (int'(v) >= ((chan == mirdc_pkg::CHAN_A) ? THR_A[k] : THR_B[k]))
                seg = k;
        end
        if (chan == mirdc_pkg::CHAN_A)
            acc = SLOPE_A[seg] * int'(v) + ICPT_A[seg];
        else
            acc = SLOPE_B[seg] * int'(v) + ICPT_B[seg];
        if (acc <= 0)
            return 8'd0;
        whole = acc / 4096;
        if (whole > 255)
            return 8'd255;
        return whole[7:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        dist_pair_t due;
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                win_a[i] = '0;
                win_b[i] = '0;
            end
            slot = 0;
            errors = 0;
            dist_due_q.delete();
        end
        else
        begin
            // compare the finishing result before taking in a new transaction
            if (done)
            begin
                if (dist_due_q.size() == 0)
                begin
                    $error("result with no transaction outstanding: a=%0d b=%0d",
                           sensor_a_distance, sensor_b_distance);
                    errors++;
                end
                else
                begin
                    due = dist_due_q.pop_front();
                    if (sensor_a_distance !== due.dist_a)
                    begin
                        $error("sensor_a_distance: expected %0d, got %0d",
                               due.dist_a, sensor_a_distance);
                        errors++;
                    end
                    if (sensor_b_distance !== due.dist_b)
                    begin
                        $error("sensor_b_distance: expected %0d, got %0d",
                               due.dist_b, sensor_b_distance);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                if (opcode == mirdc_pkg::OP_PUSH)
                begin
                    win_a[slot] = sensor_a_raw;
                    win_b[slot] = sensor_b_raw;
                    slot = (slot == WINDOW - 1) ? 0 : slot + 1;
                end
                else
                begin
                    due.dist_a = calibrated_distance(mirdc_pkg::CHAN_A, window_median(win_a));
                    due.dist_b = calibrated_distance(mirdc_pkg::CHAN_B, window_median(win_b));
                    dist_due_q.push_back(due);
                end
            end
        end
        pending = dist_due_q.size();
    end

endmodule

### sim/tb.sv
// Stimulus, clock, reset and verdict for the median IR distance converter core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW     = 8;
    localparam int ITEM_COUNT = 550;
    localparam int STALL_MAX  = 2000;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic       opcode;
    logic [7:0] sensor_a_raw;
    logic [7:0] sensor_b_raw;
    logic       done;
    logic [7:0] sensor_a_distance;
    logic [7:0] sensor_b_distance;
    int         errors;
    int         pending;
    int         sent;
    int         stall_cycles;
    bit         idle_on;

    median_ir_distance_converter_core #(.WINDOW(WINDOW)) u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .opcode            (opcode),
        .sensor_a_raw      (sensor_a_raw),
        .sensor_b_raw      (sensor_b_raw),
        .done              (done),
        .sensor_a_distance (sensor_a_distance),
        .sensor_b_distance (sensor_b_distance)
    );

    median_distance_checker #(.WINDOW(WINDOW)) u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .opcode            (opcode),
        .sensor_a_raw      (sensor_a_raw),
        .sensor_b_raw      (sensor_b_raw),
        .done              (done),
        .sensor_a_distance (sensor_a_distance),
        .sensor_b_distance (sensor_b_distance),
        .errors            (errors),
        .pending           (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // End the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_MAX)
        begin
            $display("FAIL");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Called at a rising edge; returns at the edge that accepts the transaction
    task automatic send_item(input logic op, input logic [7:0] a, input logic [7:0] b);
        while (idle_on && $urandom_range(0, 99) < 23)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        opcode       <= op;
        sensor_a_raw <= a;
        sensor_b_raw <= b;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        sent++;
    endtask

    // Hold start low until every requested distance pair is back
    task automatic drain;
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    // Bias samples toward the calibration breakpoints
    function automatic logic [7:0] pick_sample;
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, 255));
            1:       return 8'($urandom_range(0, 40));
            2:       return 8'($urandom_range(10, 100));
            default: return 8'($urandom_range(165, 190));
        endcase
    endfunction

    initial
    begin
        int n_push;
        int next_drain;
        rst_n        = 1'b0;
        start        = 1'b0;
        opcode       = mirdc_pkg::OP_PUSH;
        sensor_a_raw = '0;
        sensor_b_raw = '0;
        sent         = 0;
        idle_on      = 1'b1;
        next_drain   = 150;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // request on the cleared window, then a partly filled one
        send_item(mirdc_pkg::OP_REQUEST, 8'd0, 8'd0);
        send_item(mirdc_pkg::OP_PUSH, 8'd255, 8'd255);
        send_item(mirdc_pkg::OP_PUSH, 8'd0, 8'd0);
        send_item(mirdc_pkg::OP_REQUEST, 8'd0, 8'd0);
        repeat (5) send_item(mirdc_pkg::OP_PUSH, 8'd180, 8'd173);
        send_item(mirdc_pkg::OP_REQUEST, 8'd0, 8'd0);
        // wrap the write slot; negative and zero sums clamp to zero
        repeat (8) send_item(mirdc_pkg::OP_PUSH, 8'd29, 8'd255);
        send_item(mirdc_pkg::OP_REQUEST, 8'd0, 8'd0);
        send_item(mirdc_pkg::OP_PUSH, 8'h55, 8'hAA);
        send_item(mirdc_pkg::OP_PUSH, 8'hAA, 8'h55);
        send_item(mirdc_pkg::OP_REQUEST, 8'd0, 8'd0);

        while (sent < ITEM_COUNT)
        begin
            // long stretch with no sender gaps
            idle_on = !(sent >= 250 && sent < 350);
            if (sent >= next_drain)
            begin
                drain();
                next_drain += 250;
            end
            if ($urandom_range(0, 7) == 0)
            begin
                // noise: random opcodes and raw values
                repeat ($urandom_range(1, 6))
                    send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)));
            end
            else
            begin
                n_push = $urandom_range(0, 10);
                repeat (n_push)
                    send_item(mirdc_pkg::OP_PUSH, pick_sample(), pick_sample());
                send_item(mirdc_pkg::OP_REQUEST, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
            end
        end

        drain();
        repeat (WINDOW + 8) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
